// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on aclk outside reset
`define APR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define APR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/apr_pkg.sv
// shared types, constants and helpers of the predictive residual block
package apr_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int MAX_ORDER    = 3;
    localparam int SAMPLE_BITS  = 16;
    localparam int RES_W        = 24;
    localparam int CHAN_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 5;
    localparam int FIFO_DEPTH   = 4;

    // operating modes
    localparam logic MODE_INTER    = 1'b0;
    localparam logic MODE_TEMPORAL = 1'b1;

    // channel roles in inter-channel mode
    localparam logic [CHAN_W-1:0] MS_CHAN_A = 3'd0;
    localparam logic [CHAN_W-1:0] MS_CHAN_B = 3'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE        = 3'd0,
        CFG_LOSSY       = 3'd1,
        CFG_QUANT_BITS  = 3'd2,
        CFG_ORDER       = 3'd3,
        CFG_COEF_OLDEST = 3'd4,
        CFG_COEF_MIDDLE = 3'd5,
        CFG_COEF_NEWEST = 3'd6
    } cfg_idx_e;

    typedef struct packed {
        logic signed [RES_W-1:0] residual;
        logic [CHAN_W-1:0]       chan;
        logic                    last;
    } res_t;

    // one cycle's worth of results handed to the output queue
    typedef struct packed {
        logic [1:0] cnt;
        res_t       first;
        res_t       second;
    } push_t;

    function automatic logic signed [RES_W-1:0] sat24(input logic signed [32:0] v);
        logic signed [RES_W-1:0] r;
        if (v > 33'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (v < -33'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = v[RES_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/apr_res_fifo.sv
// small result queue taking up to two results a cycle and giving one
`include "assert_macros.svh"

module apr_res_fifo
    import apr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    input  logic  pop,
    output logic  room,
    output logic  head_valid,
    output res_t  head
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    res_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = PTR_W'(wr_ptr_reg + 1'b1);
    assign wr_ptr_next  = PTR_W'(wr_ptr_reg + PTR_W'(push.cnt));
    assign rd_ptr_next  = PTR_W'(rd_ptr_reg + PTR_W'(pop));
    assign count_next   = CNT_W'(count_reg + CNT_W'(push.cnt) - CNT_W'(pop));

    // room for a pair, whatever leaves this cycle
    assign room       = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    `APR_ASSERT_NOW(a_no_overflow, push.cnt != 2'd0, count_reg <= CNT_W'(FIFO_DEPTH - 2), "result queue overflow")
    `APR_ASSERT_NOW(a_no_underflow, pop, count_reg != '0, "pop from empty result queue")
    `APR_ASSERT_NOW(a_pair_marks, push.cnt == 2'd2, !push.first.last && push.second.last, "pair push with wrong last flags")
    `APR_ASSERT_NEXT(a_pair_lands, push.cnt == 2'd2 && !pop, count_reg == CNT_W'($past(count_reg) + 2'd2), "pair push not counted")

endmodule

// File: rtl/core/audio_predictive_residual.sv
// predictive residual block: per-channel fir prediction or mid/side pairing
// an accepted request is held in the input register, then its results are registered in the output queue
// throughput: one input request per cycle; a mid/side channel-one request gives two results,
// so the four-entry output queue throttles input on sink stalls or back-to-back pair requests
// reset: synchronous active-low aresetn clears history, held sample, queue and registers
// to their documented defaults; no clearing pass is needed afterwards
module audio_predictive_residual
    import apr_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    // input sample channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic [CHAN_W-1:0]            s_chan,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [RES_W-1:0]      m_residual,
    output logic [CHAN_W-1:0]            m_out_chan,
    output logic                         m_last,
    // configuration write channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    // configuration registers
    logic              mode_reg;
    logic              lossy_reg;
    logic [3:0]        quant_bits_reg;
    logic [1:0]        order_reg;
    logic signed [4:0] coef_oldest_reg;
    logic signed [4:0] coef_middle_reg;
    logic signed [4:0] coef_newest_reg;

    // input register stage
    logic                          in_valid_reg, in_valid_next;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic [CHAN_W-1:0]             in_chan_reg;

    // predictor state: entry MAX_ORDER-1 is the newest
    logic signed [RES_W-1:0]       hist_reg [MAX_CHANNELS][MAX_ORDER];
    logic signed [SAMPLE_BITS-1:0] held_reg;

    logic  s_accept;
    logic  proc;
    logic  room;
    logic  head_valid;
    res_t  head;
    push_t push;

    // config writes are always taken; the user must send them only while idle, which the block itself leaves unchecked
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_TEMPORAL;
            lossy_reg       <= 1'b0;
            quant_bits_reg  <= 4'd8;
            order_reg       <= 2'd1;
            coef_oldest_reg <= 5'sd0;
            coef_middle_reg <= 5'sd0;
            coef_newest_reg <= 5'sd1;
        end else if (cfg_valid) begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_MODE:        mode_reg        <= cfg_data[0];
                CFG_LOSSY:       lossy_reg       <= cfg_data[0];
                CFG_QUANT_BITS:  quant_bits_reg  <= cfg_data[3:0];
                CFG_ORDER:       order_reg       <= cfg_data[1:0];
                CFG_COEF_OLDEST: coef_oldest_reg <= cfg_data;
                CFG_COEF_MIDDLE: coef_middle_reg <= cfg_data;
                CFG_COEF_NEWEST: coef_newest_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // the input register drains whenever the queue can take a pair
    assign proc     = in_valid_reg && room;
    assign s_ready  = !in_valid_reg || proc;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_sample_reg <= s_sample;
            in_chan_reg   <= s_chan;
        end
    end

    // quantizer shift: 16 - quant_bits, so zero bits kept means a shift of 16
    logic [4:0] s_amt;
    assign s_amt = 5'd16 - {1'b0, quant_bits_reg};

    // ---------------- temporal prediction ----------------
    logic signed [RES_W-1:0] h_old, h_mid, h_new, tap_old;
    logic signed [4:0]       c_old_eff, c_mid_eff, c_new_eff;
    logic signed [28:0]      p_old, p_mid, p_new;
    logic signed [30:0]      pred;
    logic signed [31:0]      x_ext, r, q_lossy, q_sel;
    logic [31:0]             low_mask, r_trunc;
    logic signed [32:0]      fb_sum;
    logic signed [RES_W-1:0] fb;

    assign h_old = hist_reg[in_chan_reg][0];
    assign h_mid = hist_reg[in_chan_reg][1];
    assign h_new = hist_reg[in_chan_reg][MAX_ORDER-1];

    // order picks the taps; at order two the oldest coefficient sits on the middle entry
    always_comb begin
        c_old_eff = 5'sd0;
        c_mid_eff = 5'sd0;
        c_new_eff = 5'sd0;
        tap_old   = h_old;
        unique case (order_reg)
            2'd0: begin
            end
            2'd1: begin
                c_new_eff = coef_newest_reg;
            end
            2'd2: begin
                c_old_eff = coef_oldest_reg;
                c_new_eff = coef_newest_reg;
                tap_old   = h_mid;
            end
            2'd3: begin
                c_old_eff = coef_oldest_reg;
                c_mid_eff = coef_middle_reg;
                c_new_eff = coef_newest_reg;
            end
            default: ;
        endcase
    end

    assign p_old = 29'(c_old_eff) * 29'(tap_old);
    assign p_mid = 29'(c_mid_eff) * 29'(h_mid);
    assign p_new = 29'(c_new_eff) * 29'(h_new);

    assign pred = {{2{p_old[28]}}, p_old} + {{2{p_mid[28]}}, p_mid}
                + {{2{p_new[28]}}, p_new};

    assign x_ext = {{(32-SAMPLE_BITS){in_sample_reg[SAMPLE_BITS-1]}}, in_sample_reg};
    assign r     = x_ext - {pred[30], pred};

    // lossy: arithmetic shift down; reconstruction is the prediction plus the residual with low bits cleared
    assign q_lossy  = r >>> s_amt;
    assign low_mask = (32'd1 << s_amt) - 32'd1;
    assign r_trunc  = r & ~low_mask;
    assign fb_sum   = {r_trunc[31], r_trunc} + {{2{pred[30]}}, pred};

    assign q_sel = lossy_reg ? q_lossy : r;
    assign fb    = lossy_reg ? sat24(fb_sum)
                             : {{(RES_W-SAMPLE_BITS){in_sample_reg[SAMPLE_BITS-1]}},
                                in_sample_reg};

    // ---------------- mid/side pairing ----------------
    logic signed [SAMPLE_BITS:0] sum17, mid_adj, mid_half, side17, mid_q, side_q;

    assign sum17    = {held_reg[SAMPLE_BITS-1], held_reg}
                    + {in_sample_reg[SAMPLE_BITS-1], in_sample_reg};
    // add one before halving a negative sum so the result rounds toward zero
    assign mid_adj  = sum17 + {{SAMPLE_BITS{1'b0}}, sum17[SAMPLE_BITS]};
    assign mid_half = mid_adj >>> 1;
    assign side17   = {held_reg[SAMPLE_BITS-1], held_reg}
                    - {in_sample_reg[SAMPLE_BITS-1], in_sample_reg};
    assign mid_q    = lossy_reg ? (mid_half >>> s_amt) : mid_half;
    assign side_q   = lossy_reg ? (side17 >>> s_amt) : side17;

    // ---------------- results into the queue ----------------
    always_comb begin
        push.cnt             = 2'd0;
        push.first.residual  = sat24({q_sel[31], q_sel});
        push.first.chan      = in_chan_reg;
        push.first.last      = 1'b1;
        push.second.residual = {{(RES_W-SAMPLE_BITS-1){side_q[SAMPLE_BITS]}}, side_q};
        push.second.chan     = MS_CHAN_B;
        push.second.last     = 1'b1;
        if (proc) begin
            if (mode_reg == MODE_TEMPORAL) begin
                push.cnt = 2'd1;
            end else if (in_chan_reg == MS_CHAN_B) begin
                push.cnt             = 2'd2;
                push.first.residual  = {{(RES_W-SAMPLE_BITS-1){mid_q[SAMPLE_BITS]}}, mid_q};
                push.first.chan      = MS_CHAN_A;
                push.first.last      = 1'b0;
            end
        end
    end

    // history shifts on every temporal sample of its channel; held sample on channel zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                for (int k = 0; k < MAX_ORDER; k++) begin
                    hist_reg[c][k] <= '0;
                end
            end
            held_reg <= '0;
        end else if (proc) begin
            if (mode_reg == MODE_TEMPORAL) begin
                for (int k = 0; k < MAX_ORDER - 1; k++) begin
                    hist_reg[in_chan_reg][k] <= hist_reg[in_chan_reg][k+1];
                end
                hist_reg[in_chan_reg][MAX_ORDER-1] <= fb;
            end else if (in_chan_reg == MS_CHAN_A) begin
                held_reg <= in_sample_reg;
            end
        end
    end

    apr_res_fifo u_res_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (m_valid && m_ready),
        .room       (room),
        .head_valid (head_valid),
        .head       (head)
    );

    assign m_valid    = head_valid;
    assign m_residual = head.residual;
    assign m_out_chan = head.chan;
    assign m_last     = head.last;

endmodule
